// ===== sv/frd_pkg.sv =====
// Shared types and constants for the frame rms displacement block.
package frd_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int COORD_BITS    = 24;
  localparam int TYPE_W        = 8;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = 11;
  localparam int DIFF_W        = COORD_BITS + 1;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int SUM_W         = 64;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int LANES         = 4;
  localparam int LANE_W        = 2;
  localparam int DIV_STEP_W    = $clog2(SUM_W);
  localparam int STATUS_W      = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [LANE_W-1:0] LANE_TYPE = 2'd0;
  localparam logic [LANE_W-1:0] LANE_X    = 2'd1;
  localparam logic [LANE_W-1:0] LANE_Y    = 2'd2;
  localparam logic [LANE_W-1:0] LANE_Z    = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0]            ptype;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_FRAME,
    S_RSTART,
    S_RWAIT,
    S_EMIT
  } frd_state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT,
    R_DONE
  } root_state_t;

endpackage

// ===== sv/frd_root.sv =====
// Iterative floor(sqrt(sum / count)): restoring divider then bit-pair square root.
module frd_root (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [frd_pkg::SUM_W-1:0]  sum,
  input  logic [frd_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [frd_pkg::ROOT_W-1:0] root
);
  import frd_pkg::*;

  root_state_t state, state_next;
  logic [DIV_STEP_W-1:0] step;
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [SUM_W-1:0] xval;
  logic [SUM_W-1:0] res;
  logic [SUM_W-1:0] sbit;
  logic [CNT_W:0]   rem2;
  logic             ge;
  logic [SUM_W-1:0] trial;
  logic             fits;

  assign rem2  = {rem, quo[SUM_W-1]};
  assign ge    = rem2 >= {1'b0, dvs};
  assign trial = res + sbit;
  assign fits  = xval >= trial;
  assign done  = state == R_DONE;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      R_IDLE: begin
        if (start) state_next = R_DIV;
      end
      R_DIV: begin
        if (step == DIV_STEP_W'(SUM_W - 1)) state_next = R_SQRT;
      end
      R_SQRT: begin
        if (step[DIV_STEP_W-2:0] == (DIV_STEP_W-1)'(ROOT_W - 1)) state_next = R_DONE;
      end
      R_DONE: state_next = R_IDLE;
      default: state_next = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        quo  <= sum;
        dvs  <= divisor;
        rem  <= '0;
        step <= '0;
      end
      R_DIV: begin
        rem  <= ge ? CNT_W'(rem2 - {1'b0, dvs}) : rem2[CNT_W-1:0];
        quo  <= {quo[SUM_W-2:0], ge};
        step <= step + 1'b1;
        if (step == DIV_STEP_W'(SUM_W - 1)) begin
          xval <= {quo[SUM_W-2:0], ge};
          res  <= '0;
          sbit <= SUM_W'(1) << (SUM_W - 2);
          step <= '0;
        end
      end
      R_SQRT: begin
        if (fits) begin
          xval <= xval - trial;
          res  <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/frame_rms_displacement.sv =====
// Top level: rms displacement of particle positions between consecutive frames.
//
// Input channel: one particle per item (type, x, y, z in signed Q12.12 and an
// end_of_frame mark), taken when in_valid is high and in_stall is low.
// Each particle is accepted in S_IDLE, which also reads the stored particle at
// the same index; then each of four lanes (type, x, y, z) passes S_DIFF, S_MUL
// and S_ACC, through one shared subtract, one multiplier and one adder.
// On the last particle of a frame, when a previous frame exists and the counts
// match and are not zero, each lane runs the shared root unit: 64 divide steps
// and 32 square root steps. The first frame gives no result.
// Output channel: one item per frame after the first, held in an output
// register until taken (out_valid high, out_stall low). While a result waits,
// new particles are still accepted; a second frame end waits for the register.
// Reset holds in_stall high and clears counts, sums and the valid flags; the
// particle store is not cleared; only entries written by the previous frame are used.
module frame_rms_displacement (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [frd_pkg::TYPE_W-1:0]            particle_type,
  input  logic signed [frd_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [frd_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [frd_pkg::COORD_BITS-1:0] pos_z,
  input  logic                                  end_of_frame,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [frd_pkg::TYPE_W-1:0]            rms_type,
  output logic [frd_pkg::COORD_BITS-1:0]        rms_x,
  output logic [frd_pkg::COORD_BITS-1:0]        rms_y,
  output logic [frd_pkg::COORD_BITS-1:0]        rms_z,
  output logic [frd_pkg::CNT_W-1:0]             particle_count,
  output logic [frd_pkg::STATUS_W-1:0]          status
);
  import frd_pkg::*;

  frd_state_t state, state_next;

  entry_t mem [MAX_PARTICLES];
  entry_t rdata;
  entry_t cur;
  logic   last;
  logic   cmp;

  logic [CNT_W-1:0]  cur_count;
  logic [CNT_W-1:0]  prev_count;
  logic              have_prev;
  logic              ovf;
  logic [SUM_W-1:0]  sums [LANES];
  logic [LANE_W-1:0] lane;
  logic [DIFF_W-1:0] mag;
  logic [SQ_W-1:0]   prod;
  logic              rms_ok;
  logic [ROOT_W-1:0] res [LANES];

  logic                     accept;
  logic                     emit_free;
  logic                     root_done;
  logic [ROOT_W-1:0]        root;
  logic signed [DIFF_W-1:0] op_a;
  logic signed [DIFF_W-1:0] op_b;
  logic signed [DIFF_W-1:0] diff;
  logic                     match;

  assign in_stall  = rst || state != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign emit_free = !out_valid || !out_stall;
  assign match     = cur_count == prev_count;

  always_comb begin
    unique case (lane)
      LANE_TYPE: begin
        op_a = DIFF_W'($signed({1'b0, cur.ptype}));
        op_b = DIFF_W'($signed({1'b0, rdata.ptype}));
      end
      LANE_X: begin
        op_a = DIFF_W'(cur.x);
        op_b = DIFF_W'(rdata.x);
      end
      LANE_Y: begin
        op_a = DIFF_W'(cur.y);
        op_b = DIFF_W'(rdata.y);
      end
      LANE_Z: begin
        op_a = DIFF_W'(cur.z);
        op_b = DIFF_W'(rdata.z);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    diff = op_a - op_b;
  end

  frd_root u_root (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_RSTART),
    .sum     (sums[lane]),
    .divisor (cur_count),
    .done    (root_done),
    .root    (root)
  );

  always_ff @(posedge clk) begin
    if (accept && cur_count < CNT_W'(MAX_PARTICLES)) begin
      mem[cur_count[IDX_W-1:0]] <= '{particle_type, pos_x, pos_y, pos_z};
      rdata <= mem[cur_count[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_DIFF;
      S_DIFF:   state_next = S_MUL;
      S_MUL:    state_next = S_ACC;
      S_ACC: begin
        if (lane == LANE_Z) state_next = last ? S_FRAME : S_IDLE;
        else state_next = S_DIFF;
      end
      S_FRAME: begin
        if (!have_prev) state_next = S_IDLE;
        else if (match && cur_count != '0) state_next = S_RSTART;
        else state_next = S_EMIT;
      end
      S_RSTART: state_next = S_RWAIT;
      S_RWAIT: begin
        if (root_done) state_next = (lane == LANE_Z) ? S_EMIT : S_RSTART;
      end
      S_EMIT:   if (emit_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_count  <= '0;
      prev_count <= '0;
      have_prev  <= 1'b0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
      lane       <= '0;
      for (int i = 0; i < LANES; i++) sums[i] <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur  <= '{particle_type, pos_x, pos_y, pos_z};
            last <= end_of_frame;
            lane <= '0;
            if (cur_count < CNT_W'(MAX_PARTICLES)) begin
              cmp       <= have_prev && cur_count < prev_count;
              cur_count <= cur_count + 1'b1;
            end else begin
              cmp <= 1'b0;
              ovf <= 1'b1;
            end
          end
        end
        S_DIFF: mag <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        S_MUL:  prod <= SQ_W'(mag) * SQ_W'(mag);
        S_ACC: begin
          if (cmp) sums[lane] <= sums[lane] + SUM_W'(prod);
          lane <= lane + 1'b1;
        end
        S_FRAME: begin
          lane   <= '0;
          rms_ok <= match && cur_count != '0;
          if (!have_prev) begin
            prev_count <= cur_count;
            have_prev  <= 1'b1;
            cur_count  <= '0;
            ovf        <= 1'b0;
            for (int i = 0; i < LANES; i++) sums[i] <= '0;
          end
        end
        S_RWAIT: begin
          if (root_done) begin
            res[lane] <= root;
            lane      <= lane + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_free) begin
            out_valid      <= 1'b1;
            rms_type       <= !rms_ok ? '0 :
                              (res[LANE_TYPE] > ROOT_W'({TYPE_W{1'b1}})) ? '1 :
                              res[LANE_TYPE][TYPE_W-1:0];
            rms_x          <= !rms_ok ? '0 :
                              (res[LANE_X] > ROOT_W'({COORD_BITS{1'b1}})) ? '1 :
                              res[LANE_X][COORD_BITS-1:0];
            rms_y          <= !rms_ok ? '0 :
                              (res[LANE_Y] > ROOT_W'({COORD_BITS{1'b1}})) ? '1 :
                              res[LANE_Y][COORD_BITS-1:0];
            rms_z          <= !rms_ok ? '0 :
                              (res[LANE_Z] > ROOT_W'({COORD_BITS{1'b1}})) ? '1 :
                              res[LANE_Z][COORD_BITS-1:0];
            particle_count <= cur_count;
            status         <= ovf ? ST_OVERFLOW : (match ? ST_OK : ST_MISMATCH);
            prev_count     <= cur_count;
            have_prev      <= 1'b1;
            cur_count      <= '0;
            ovf            <= 1'b0;
            for (int i = 0; i < LANES; i++) sums[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cur_count <= CNT_W'(MAX_PARTICLES))
    else $error("particle count beyond store depth");

  a_root_done_wait: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == S_RWAIT)
    else $error("root result with no pending request");

  a_accept_diff: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DIFF)
    else $error("accepted item did not start lane work");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_free) |=> out_valid)
    else $error("frame result not presented");
`endif

endmodule

// ===== test/tb_frame_rms_displacement.sv =====
// Testbench for frame_rms_displacement: fixed and random particle frames against a behavioral predictor.
module tb_frame_rms_displacement;
  import frd_pkg::*;

  typedef struct {
    logic [TYPE_W-1:0]            ptype;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         eof;
  } particle_t;

  typedef struct {
    logic [TYPE_W-1:0]     rt;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    logic [COORD_BITS-1:0] rz;
    logic [CNT_W-1:0]      cnt;
    logic [STATUS_W-1:0]   st;
  } frame_rms_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [TYPE_W-1:0] rms_type;
  logic [COORD_BITS-1:0] rms_x, rms_y, rms_z;
  logic [CNT_W-1:0] particle_count;
  logic [STATUS_W-1:0] status;
  particle_t cur = '{default: '0};

  particle_t  pending[$];
  frame_rms_t expected_rms[$];
  int total_items = 0;
  int accepted = 0;
  int errors = 0;
  int send_idle = 20;
  int recv_idle = 81;
  int hold_left = 0;
  bit hold_done = 0;

  // predictor state
  logic [TYPE_W-1:0]            ref_type[MAX_PARTICLES];
  logic signed [COORD_BITS-1:0] ref_x[MAX_PARTICLES];
  logic signed [COORD_BITS-1:0] ref_y[MAX_PARTICLES];
  logic signed [COORD_BITS-1:0] ref_z[MAX_PARTICLES];
  int unsigned last_count = 0;
  bit          have_last = 0;
  int unsigned run_count = 0;
  logic [63:0] acc_t = 0, acc_x = 0, acc_y = 0, acc_z = 0;
  bit          overflowed = 0;

  frame_rms_displacement dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .particle_type(cur.ptype), .pos_x(cur.x), .pos_y(cur.y), .pos_z(cur.z),
    .end_of_frame(cur.eof), .out_valid(out_valid), .out_stall(out_stall),
    .rms_type(rms_type), .rms_x(rms_x), .rms_y(rms_y), .rms_z(rms_z),
    .particle_count(particle_count), .status(status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] sq_dist(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic logic [63:0] mean_root(logic [63:0] sum, int unsigned n,
                                            logic [63:0] cap);
    logic [63:0] r;
    r = floor_root(sum / n);
    return (r > cap) ? cap : r;
  endfunction

  task automatic predict_particle(particle_t p);
    int unsigned idx;
    frame_rms_t r;
    bit match;
    idx = run_count;
    if (idx < MAX_PARTICLES) begin
      if (have_last && idx < last_count) begin
        acc_t += sq_dist(longint'(p.ptype), longint'(ref_type[idx]));
        acc_x += sq_dist(longint'(p.x), longint'(ref_x[idx]));
        acc_y += sq_dist(longint'(p.y), longint'(ref_y[idx]));
        acc_z += sq_dist(longint'(p.z), longint'(ref_z[idx]));
      end
      ref_type[idx] = p.ptype;
      ref_x[idx] = p.x;
      ref_y[idx] = p.y;
      ref_z[idx] = p.z;
      run_count = idx + 1;
    end else begin
      overflowed = 1;
    end
    if (p.eof) begin
      if (have_last) begin
        match = (run_count == last_count);
        r = '{default: '0};
        r.st = overflowed ? ST_OVERFLOW : (match ? ST_OK : ST_MISMATCH);
        if (match && run_count != 0) begin
          r.rt = TYPE_W'(mean_root(acc_t, run_count, 64'hFF));
          r.rx = COORD_BITS'(mean_root(acc_x, run_count, 64'hFFFFFF));
          r.ry = COORD_BITS'(mean_root(acc_y, run_count, 64'hFFFFFF));
          r.rz = COORD_BITS'(mean_root(acc_z, run_count, 64'hFFFFFF));
        end
        r.cnt = run_count[CNT_W-1:0];
        expected_rms = {expected_rms, r};
      end
      last_count = run_count;
      have_last = 1;
      run_count = 0;
      acc_t = 0; acc_x = 0; acc_y = 0; acc_z = 0;
      overflowed = 0;
    end
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(9))
      0: return {1'b1, {(COORD_BITS-1){1'b0}}};
      1: return {1'b0, {(COORD_BITS-1){1'b1}}};
      2: return COORD_BITS'($urandom_range(15));
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_frame(int n);
    particle_t p;
    for (int i = 0; i < n; i++) begin
      p.ptype = TYPE_W'($urandom);
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
      p.eof = (i == n - 1);
      pending = {pending, p};
    end
  endtask

  task automatic queue_fixed(int n, logic [TYPE_W-1:0] t, logic [COORD_BITS-1:0] c);
    particle_t p;
    for (int i = 0; i < n; i++) begin
      p.ptype = t;
      p.x = c;
      p.y = ~c;
      p.z = c;
      p.eof = (i == n - 1);
      pending = {pending, p};
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_particle(cur);
        void'(pending.pop_front());
        accepted++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur <= pending[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && accepted > total_items / 2) begin
      hold_done <= 1;
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    frame_rms_t e;
    if (rst) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rms.size() == 0) begin
          $error("unexpected result: status %0d count %0d", status, particle_count);
          errors++;
        end else begin
          e = expected_rms.pop_front();
          if (rms_type !== e.rt) begin
            $error("rms_type expected %0d got %0d", e.rt, rms_type); errors++;
          end
          if (rms_x !== e.rx) begin
            $error("rms_x expected %0h got %0h", e.rx, rms_x); errors++;
          end
          if (rms_y !== e.ry) begin
            $error("rms_y expected %0h got %0h", e.ry, rms_y); errors++;
          end
          if (rms_z !== e.rz) begin
            $error("rms_z expected %0h got %0h", e.rz, rms_z); errors++;
          end
          if (particle_count !== e.cnt) begin
            $error("particle_count expected %0d got %0d", e.cnt, particle_count); errors++;
          end
          if (status !== e.st) begin
            $error("status expected %0d got %0d", e.st, status); errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // idle profile by progress
  always @(posedge clk) begin
    if (accepted > (2 * total_items) / 3) begin
      send_idle <= 0;
      recv_idle <= 0;
    end else if (accepted > total_items / 3) begin
      send_idle <= 81;
      recv_idle <= 20;
    end
  end

  initial begin
    int n;
    int prev_n;
    queue_fixed(3, 8'd0, {1'b1, {(COORD_BITS-1){1'b0}}});
    queue_fixed(3, 8'hFF, {1'b0, {(COORD_BITS-1){1'b1}}});
    queue_fixed(3, 8'hFF, {1'b0, {(COORD_BITS-1){1'b1}}});
    queue_frame(2);
    queue_frame(1);
    queue_frame(1);
    queue_frame(4);
    queue_frame(4);
    prev_n = 4;
    while (pending.size() < 445) begin
      n = ($urandom_range(99) < 70) ? prev_n : $urandom_range(1, 12);
      queue_frame(n);
      prev_n = n;
    end
    total_items = pending.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || in_valid) @(posedge clk);
    while (expected_rms.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_rms.size() == 0) begin
      $display("tb_frame_rms_displacement: done, clean");
    end else begin
      $display("tb_frame_rms_displacement: done, errors");
    end
    $finish;
  end

  initial begin
    #(8 * 1500000);
    $display("tb_frame_rms_displacement: done, errors");
    $finish;
  end

endmodule

// ===== frame_rms_displacement.f =====
sv/frd_pkg.sv
sv/frd_root.sv
sv/frame_rms_displacement.sv
test/tb_frame_rms_displacement.sv
